// ===== rtl/core/text_stream_cat_filter_macros.svh =====
// Assertion macros used by the checker of the text stream filter.
`ifndef TEXT_STREAM_CAT_FILTER_MACROS_SVH
`define TEXT_STREAM_CAT_FILTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSCF_ASSERT_SAME(label, clk, dis, pre, post) \
  label: assert property (@(posedge clk) disable iff (dis) (pre) |-> (post)) \
    else $error("tscf: same-cycle property violated");

// The consequent must hold in the cycle after the antecedent.
`define TSCF_ASSERT_NEXT(label, clk, dis, pre, post) \
  label: assert property (@(posedge clk) disable iff (dis) (pre) |=> (post)) \
    else $error("tscf: next-cycle property violated");

`endif

// ===== rtl/core/tscf_pkg.sv =====
// Types and constants shared by the text stream filter modules.
`default_nettype none

package tscf_pkg;

  localparam int unsigned COUNT_DIGITS = 6;
  localparam int unsigned COUNT_W      = 4 * COUNT_DIGITS;
  localparam int unsigned PREFIX_LEN   = COUNT_DIGITS + 1;
  localparam int unsigned TAIL_MAX     = 4;
  localparam int unsigned MAX_RESULTS  = PREFIX_LEN + TAIL_MAX;
  localparam int unsigned LEN_W        = $clog2(MAX_RESULTS + 1);
  localparam int unsigned CFG_INDEX_W  = 3;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_NUMBER_ALL      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_NUMBER_NONBLANK = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SQUEEZE         = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SHOW_ENDS       = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_SHOW_TABS       = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_SHOW_NONPRINT   = 3'd5;

  // Character codes.
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_NL       = 8'h0A;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_DOLLAR   = 8'h24;
  localparam logic [7:0] CH_DASH     = 8'h2D;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_QMARK    = 8'h3F;
  localparam logic [7:0] CH_I        = 8'h49;
  localparam logic [7:0] CH_M        = 8'h4D;
  localparam logic [7:0] CH_CARET    = 8'h5E;
  localparam logic [7:0] CH_DEL      = 8'd127;
  localparam logic [7:0] CH_TOP      = 8'd255;
  localparam logic [7:0] CTRL_LIMIT  = 8'd32;
  localparam logic [7:0] HIGH_BASE   = 8'd128;
  localparam logic [7:0] META_LIMIT  = 8'd160;
  localparam logic [7:0] CARET_SHIFT = 8'd64;

  typedef logic [COUNT_W-1:0] count_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic number_all_lines;
    logic number_nonblank_lines;
    logic squeeze_blank_runs;
    logic show_line_ends;
    logic show_tabs;
    logic show_nonprinting;
  } cfg_t;

  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] bytes;
    logic [LEN_W-1:0]            len;
  } expansion_t;

endpackage

`default_nettype wire

// ===== rtl/core/tscf_render.sv =====
// Line state and per-byte rendering of one text byte into its output bytes.
`default_nettype none

module tscf_render (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire tscf_pkg::cfg_t        cfg,
  input  wire tscf_pkg::in_item_t    item,
  input  wire logic                  advance,
  output tscf_pkg::expansion_t       exp
);

  logic                    at_line_start;
  logic [1:0]              empty_line_run;
  tscf_pkg::count_t        all_line_count;
  tscf_pkg::count_t        nonblank_line_count;

  logic                    eff_at_start;
  logic [1:0]              eff_run;
  tscf_pkg::count_t        eff_all;
  tscf_pkg::count_t        eff_nb;
  logic [7:0]              ch;
  logic                    is_nl;
  logic                    blank_hit;
  logic                    drop;
  logic                    use_nb;
  logic                    use_all;
  logic                    has_prefix;
  logic                    seen;
  logic [3:0]              digit;
  tscf_pkg::count_t        number;
  logic [1:0]              empty_line_run_next;
  tscf_pkg::count_t        all_line_count_next;
  tscf_pkg::count_t        nonblank_line_count_next;
  logic [tscf_pkg::PREFIX_LEN-1:0][7:0] prefix_bytes;
  logic [tscf_pkg::TAIL_MAX-1:0][7:0]   tail_bytes;
  logic [tscf_pkg::LEN_W-1:0]           tail_len;

  // Adds one to a BCD count; an all-nines count stays as it is.
  function automatic tscf_pkg::count_t bcd_increment(input tscf_pkg::count_t v);
    tscf_pkg::count_t r;
    logic             carry;
    r     = v;
    carry = 1'b1;
    for (int i = 0; i < tscf_pkg::COUNT_DIGITS; i++) begin
      if (carry) begin
        if (v[4*i +: 4] == 4'd9) begin
          r[4*i +: 4] = 4'd0;
        end else begin
          r[4*i +: 4] = v[4*i +: 4] + 4'd1;
          carry       = 1'b0;
        end
      end
    end
    return carry ? v : r;
  endfunction

  always_comb begin
    ch           = item.data_byte;
    eff_at_start = item.start_of_file ? 1'b1 : at_line_start;
    eff_run      = item.start_of_file ? 2'd0 : empty_line_run;
    eff_all      = item.start_of_file ? tscf_pkg::COUNT_W'(1) : all_line_count;
    eff_nb       = item.start_of_file ? tscf_pkg::COUNT_W'(1) : nonblank_line_count;
    is_nl        = (ch == tscf_pkg::CH_NL);

    blank_hit = cfg.squeeze_blank_runs && is_nl && eff_at_start;
    if (!blank_hit) begin
      empty_line_run_next = 2'd0;
    end else if (eff_run == 2'd2) begin
      empty_line_run_next = 2'd2;
    end else begin
      empty_line_run_next = eff_run + 2'd1;
    end
    drop = blank_hit && (empty_line_run_next == 2'd2);

    use_nb     = eff_at_start && cfg.number_nonblank_lines && !is_nl;
    use_all    = eff_at_start && !cfg.number_nonblank_lines && cfg.number_all_lines;
    has_prefix = !drop && (use_nb || use_all);
    number     = use_nb ? eff_nb : eff_all;

    all_line_count_next      = (!drop && use_all) ? bcd_increment(eff_all) : eff_all;
    nonblank_line_count_next = (!drop && use_nb) ? bcd_increment(eff_nb) : eff_nb;

    // Leading zeros print as spaces; the units digit is always shown.
    seen = 1'b0;
    for (int k = 0; k < tscf_pkg::COUNT_DIGITS; k++) begin
      digit = number[4*(tscf_pkg::COUNT_DIGITS-1-k) +: 4];
      if (digit != 4'd0 || k == tscf_pkg::COUNT_DIGITS - 1) begin
        seen = 1'b1;
      end
      prefix_bytes[k] = seen ? (tscf_pkg::CH_ZERO + {4'd0, digit}) : tscf_pkg::CH_SPACE;
    end
    prefix_bytes[tscf_pkg::PREFIX_LEN-1] = tscf_pkg::CH_TAB;

    tail_bytes = '0;
    if (is_nl) begin
      if (cfg.show_line_ends) begin
        tail_bytes[0] = tscf_pkg::CH_DOLLAR;
        tail_bytes[1] = tscf_pkg::CH_NL;
        tail_len      = tscf_pkg::LEN_W'(2);
      end else begin
        tail_bytes[0] = tscf_pkg::CH_NL;
        tail_len      = tscf_pkg::LEN_W'(1);
      end
    end else if (cfg.show_tabs && ch == tscf_pkg::CH_TAB) begin
      tail_bytes[0] = tscf_pkg::CH_CARET;
      tail_bytes[1] = tscf_pkg::CH_I;
      tail_len      = tscf_pkg::LEN_W'(2);
    end else if (cfg.show_nonprinting &&
                 ((ch < tscf_pkg::CTRL_LIMIT && ch != tscf_pkg::CH_TAB) ||
                  ch == tscf_pkg::CH_DEL)) begin
      tail_bytes[0] = tscf_pkg::CH_CARET;
      tail_bytes[1] = (ch == tscf_pkg::CH_DEL) ? tscf_pkg::CH_QMARK :
                      8'(ch + tscf_pkg::CARET_SHIFT);
      tail_len      = tscf_pkg::LEN_W'(2);
    end else if (cfg.show_nonprinting && ch >= tscf_pkg::HIGH_BASE) begin
      tail_bytes[0] = tscf_pkg::CH_M;
      tail_bytes[1] = tscf_pkg::CH_DASH;
      if (ch == tscf_pkg::CH_TOP) begin
        tail_bytes[2] = tscf_pkg::CH_CARET;
        tail_bytes[3] = tscf_pkg::CH_QMARK;
        tail_len      = tscf_pkg::LEN_W'(4);
      end else if (ch < tscf_pkg::META_LIMIT) begin
        tail_bytes[2] = tscf_pkg::CH_CARET;
        tail_bytes[3] = 8'(ch - tscf_pkg::CARET_SHIFT);
        tail_len      = tscf_pkg::LEN_W'(4);
      end else begin
        tail_bytes[2] = 8'(ch - tscf_pkg::HIGH_BASE);
        tail_len      = tscf_pkg::LEN_W'(3);
      end
    end else begin
      tail_bytes[0] = ch;
      tail_len      = tscf_pkg::LEN_W'(1);
    end

    exp.bytes = has_prefix ? {tail_bytes, prefix_bytes} :
                             {(8 * tscf_pkg::PREFIX_LEN)'(0), tail_bytes};
    if (drop) begin
      exp.len = '0;
    end else if (has_prefix) begin
      exp.len = tscf_pkg::LEN_W'(tscf_pkg::PREFIX_LEN) + tail_len;
    end else begin
      exp.len = tail_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      at_line_start       <= 1'b1;
      empty_line_run      <= 2'd0;
      all_line_count      <= tscf_pkg::COUNT_W'(1);
      nonblank_line_count <= tscf_pkg::COUNT_W'(1);
    end else if (advance) begin
      at_line_start       <= is_nl;
      empty_line_run      <= empty_line_run_next;
      all_line_count      <= all_line_count_next;
      nonblank_line_count <= nonblank_line_count_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/tscf_serializer.sv =====
// Result register that hands out one rendered byte per output transaction.
`default_nettype none

module tscf_serializer (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 load,
  input  wire tscf_pkg::expansion_t exp,
  output logic                      free,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output tscf_pkg::out_item_t       out_data
);

  logic [tscf_pkg::MAX_RESULTS-1:0][7:0] bytes;
  logic [tscf_pkg::LEN_W-1:0]            remaining;
  logic                                  last;

  assign last                 = (remaining == tscf_pkg::LEN_W'(1));
  assign free                 = !out_valid || (out_ready && last);
  assign out_data.out_byte    = bytes[0];
  assign out_data.last_of_run = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      remaining <= '0;
    end else if (load) begin
      // An expansion of length zero (a squeezed line) leaves the register empty.
      out_valid <= (exp.len != '0);
      remaining <= exp.len;
      bytes     <= exp.bytes;
    end else if (out_valid && out_ready) begin
      out_valid <= !last;
      remaining <= remaining - tscf_pkg::LEN_W'(1);
      bytes     <= {8'h00, bytes[tscf_pkg::MAX_RESULTS-1:1]};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/text_stream_cat_filter.sv =====
// Top level of the text stream filter: configuration, input register and datapath.
`default_nettype none

// Text filter with line numbering, blank-line squeezing and visible rendering of
// tabs, line ends and non-printing bytes. Each input transaction carries one text
// byte and yields zero to eleven output transactions, the last of which carries
// last_of_run. An accepted byte sits in an input register, is rendered into the
// result register once that is free and leaves it one byte per cycle while
// out_ready is high; the first output byte is presented after the byte has moved
// from the input register into the result register. The sustained rate is one
// input byte per cycle when every byte renders to one byte and the output does
// not stall; a longer rendering holds the result register until its last byte
// has left through the one-byte-wide output serializer. A squeezed empty line
// produces nothing. The input register takes the next byte while the result
// register is still draining. Configuration writes are always accepted and are
// meant to happen only while the block is idle.
module text_stream_cat_filter (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire tscf_pkg::in_item_t                in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output tscf_pkg::out_item_t                    out_data,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [tscf_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic                              cfg_data
);

  tscf_pkg::cfg_t       cfg;
  tscf_pkg::in_item_t   in_item;
  logic                 in_full;
  logic                 ser_free;
  logic                 move;
  tscf_pkg::expansion_t exp;

  assign cfg_ready = 1'b1;
  assign move      = in_full && ser_free;
  assign in_ready  = !in_full || move;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tscf_pkg::CFG_NUMBER_ALL:      cfg.number_all_lines      <= cfg_data;
        tscf_pkg::CFG_NUMBER_NONBLANK: cfg.number_nonblank_lines <= cfg_data;
        tscf_pkg::CFG_SQUEEZE:         cfg.squeeze_blank_runs    <= cfg_data;
        tscf_pkg::CFG_SHOW_ENDS:       cfg.show_line_ends        <= cfg_data;
        tscf_pkg::CFG_SHOW_TABS:       cfg.show_tabs             <= cfg_data;
        tscf_pkg::CFG_SHOW_NONPRINT:   cfg.show_nonprinting      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
      in_item <= in_data;
    end else if (move) begin
      in_full <= 1'b0;
    end
  end

  tscf_render u_render (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .item    (in_item),
    .advance (move),
    .exp     (exp)
  );

  tscf_serializer u_serializer (
    .clk       (clk),
    .rst       (rst),
    .load      (move),
    .exp       (exp),
    .free      (ser_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== rtl/core/tscf_checker.sv =====
// Port-level checker for the text stream filter and its bind to the top level.
`default_nettype none

module tscf_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              in_valid,
  input wire logic                              in_ready,
  input wire tscf_pkg::in_item_t                in_data,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire tscf_pkg::out_item_t               out_data,
  input wire logic                              cfg_valid,
  input wire logic                              cfg_ready,
  input wire logic [tscf_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input wire logic                              cfg_data
);

`include "text_stream_cat_filter_macros.svh"

  // A stalled output transaction keeps its byte and its end mark.
  `TSCF_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data))

  // The output side comes out of reset empty.
  `TSCF_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !out_valid)

  // With nothing waiting at the output, the input side can always take a byte.
  `TSCF_ASSERT_SAME(a_ready_when_drained, clk, rst, !out_valid, in_ready)

  // An expansion is sent without gaps until its last byte.
  `TSCF_ASSERT_NEXT(a_run_continues, clk, rst,
                    out_valid && out_ready && !out_data.last_of_run, out_valid)

endmodule

bind text_stream_cat_filter tscf_checker u_tscf_checker (.*);

`default_nettype wire

// ===== tb/sv/text_stream_cat_filter_tb.sv =====
// Self-checking testbench for the text stream filter, with its own rendering predictor.
module text_stream_cat_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tscf_pkg::*;

  localparam int CYCLE_LIMIT   = 200_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 33;
  localparam int NUM_INDEXES   = 1 << CFG_INDEX_W;

  localparam cfg_t MODE_PLAIN = '0;
  localparam cfg_t MODE_SHOW = '{number_all_lines: 1'b1, number_nonblank_lines: 1'b0,
                                 squeeze_blank_runs: 1'b0, show_line_ends: 1'b1,
                                 show_tabs: 1'b1, show_nonprinting: 1'b1};
  localparam cfg_t MODE_SQUEEZE = '{number_all_lines: 1'b1, number_nonblank_lines: 1'b1,
                                    squeeze_blank_runs: 1'b1, show_line_ends: 1'b1,
                                    show_tabs: 1'b0, show_nonprinting: 1'b0};

  typedef struct {
    cfg_t       mode;
    logic [7:0] data_byte;
    logic       start_of_file;
    bit         known;
    string      golden;
  } text_vector_t;

  // Rows marked known carry their rendering; the rest are left to the predictor.
  text_vector_t directed_vectors[$] = '{
    '{MODE_PLAIN,   8'h41, 1'b1, 1'b1, "A"},
    '{MODE_PLAIN,   8'hFF, 1'b0, 1'b1, "\377"},
    '{MODE_PLAIN,   8'h0A, 1'b0, 1'b1, "\n"},
    '{MODE_SHOW,    8'h00, 1'b1, 1'b1, "     1\t^@"},
    '{MODE_SHOW,    8'h1F, 1'b0, 1'b1, "^_"},
    '{MODE_SHOW,    8'h09, 1'b0, 1'b1, "^I"},
    '{MODE_SHOW,    8'h7F, 1'b0, 1'b1, "^?"},
    '{MODE_SHOW,    8'h80, 1'b0, 1'b1, "M-^@"},
    '{MODE_SHOW,    8'h9F, 1'b0, 1'b1, "M-^_"},
    '{MODE_SHOW,    8'hA0, 1'b0, 1'b1, "M- "},
    '{MODE_SHOW,    8'hFE, 1'b0, 1'b1, "M-~"},
    '{MODE_SHOW,    8'hFF, 1'b0, 1'b1, "M-^?"},
    '{MODE_SHOW,    8'h0A, 1'b0, 1'b1, "$\n"},
    '{MODE_SHOW,    8'hFF, 1'b0, 1'b1, "     2\tM-^?"},
    '{MODE_SHOW,    8'h0A, 1'b0, 1'b1, "$\n"},
    '{MODE_SHOW,    8'h0A, 1'b0, 1'b1, "     3\t$\n"},
    '{MODE_SHOW,    8'h5A, 1'b0, 1'b0, ""},
    '{MODE_SQUEEZE, 8'h0A, 1'b1, 1'b1, "$\n"},
    '{MODE_SQUEEZE, 8'h0A, 1'b0, 1'b1, ""},
    '{MODE_SQUEEZE, 8'h0A, 1'b0, 1'b1, ""},
    '{MODE_SQUEEZE, 8'h78, 1'b0, 1'b1, "     1\tx"},
    '{MODE_SQUEEZE, 8'h0A, 1'b0, 1'b1, "$\n"},
    '{MODE_SQUEEZE, 8'h41, 1'b1, 1'b1, "     1\tA"},
    '{MODE_SQUEEZE, 8'h09, 1'b0, 1'b0, ""}
  };

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  in_item_t               in_data = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_item_t              out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic                   cfg_data = 1'b0;

  // Predictor state.
  cfg_t       mode = '0;
  logic       at_start = 1'b1;
  logic [1:0] blank_run = '0;
  count_t     line_no_all = count_t'(1);
  count_t     line_no_text = count_t'(1);

  logic [7:0] rendered[$];
  out_item_t  expected_bytes[$];
  out_item_t  oldest;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int failures = 0;
  int bytes_checked = 0;
  int items_sent = 0;
  int settings_applied = 0;
  int cycle_count = 0;

  text_stream_cat_filter uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic count_t bcd_next(input count_t v);
    count_t r;
    int     i;
    r = v;
    for (i = 0; i < COUNT_DIGITS; i++) begin
      if (v[4*i +: 4] < 4'd9) begin
        r[4*i +: 4] = v[4*i +: 4] + 4'd1;
        return r;
      end
      r[4*i +: 4] = 4'd0;
    end
    return v;
  endfunction

  task automatic push_line_number(input count_t v);
    int         i;
    logic [3:0] digit;
    bit         leading;
    leading = 1'b1;
    for (i = COUNT_DIGITS - 1; i >= 0; i--) begin
      digit = v[4*i +: 4];
      if (digit > 4'd9) digit = 4'd9;
      if (digit != 4'd0 || i == 0) leading = 1'b0;
      rendered.push_back(leading ? CH_SPACE : CH_ZERO + 8'(digit));
    end
    rendered.push_back(CH_TAB);
  endtask

  // Fills rendered with the bytes that one input byte should produce.
  task automatic predict_rendering(input in_item_t item);
    logic [7:0] ch;
    ch = item.data_byte;
    rendered.delete();
    if (item.start_of_file) begin
      at_start = 1'b1;
      blank_run = '0;
      line_no_all = count_t'(1);
      line_no_text = count_t'(1);
    end
    if (mode.squeeze_blank_runs && ch == CH_NL && at_start) begin
      if (blank_run < 2'd2) blank_run = blank_run + 2'd1;
      if (blank_run > 2'd1) return;
    end else begin
      blank_run = '0;
    end
    if (at_start) begin
      if (mode.number_nonblank_lines) begin
        if (ch != CH_NL) begin
          push_line_number(line_no_text);
          line_no_text = bcd_next(line_no_text);
        end
      end else if (mode.number_all_lines) begin
        push_line_number(line_no_all);
        line_no_all = bcd_next(line_no_all);
      end
    end
    if (mode.show_line_ends && ch == CH_NL) rendered.push_back(CH_DOLLAR);
    if (mode.show_tabs && ch == CH_TAB) begin
      rendered.push_back(CH_CARET);
      rendered.push_back(CH_I);
    end else if (mode.show_nonprinting &&
                 ((ch < CTRL_LIMIT && ch != CH_NL && ch != CH_TAB) || ch == CH_DEL)) begin
      rendered.push_back(CH_CARET);
      rendered.push_back(ch == CH_DEL ? CH_QMARK : ch + CARET_SHIFT);
    end else if (mode.show_nonprinting && ch >= HIGH_BASE) begin
      rendered.push_back(CH_M);
      rendered.push_back(CH_DASH);
      if (ch == CH_TOP) begin
        rendered.push_back(CH_CARET);
        rendered.push_back(CH_QMARK);
      end else if (ch < META_LIMIT) begin
        rendered.push_back(CH_CARET);
        rendered.push_back(ch - CARET_SHIFT);
      end else begin
        rendered.push_back(ch - HIGH_BASE);
      end
    end else begin
      rendered.push_back(ch);
    end
    at_start = (ch == CH_NL);
  endtask

  task automatic send_byte(input in_item_t item, input bit known, input string golden);
    int i;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    predict_rendering(item);
    if (known) begin
      rendered.delete();
      for (i = 0; i < golden.len(); i++) rendered.push_back(golden[i]);
    end
    for (i = 0; i < rendered.size(); i++)
      expected_bytes.push_back('{out_byte: rendered[i], last_of_run: (i == rendered.size() - 1)});
  endtask

  // A squeezed line leaves nothing to wait for, so a settling wait follows the drained queue.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_mode(input cfg_t m);
    int                     i;
    logic [CFG_INDEX_W-1:0] idx;
    logic                   bit_val;
    for (i = 0; i < NUM_INDEXES; i++) begin
      idx = i[CFG_INDEX_W-1:0];
      case (idx)
        CFG_NUMBER_ALL:      bit_val = m.number_all_lines;
        CFG_NUMBER_NONBLANK: bit_val = m.number_nonblank_lines;
        CFG_SQUEEZE:         bit_val = m.squeeze_blank_runs;
        CFG_SHOW_ENDS:       bit_val = m.show_line_ends;
        CFG_SHOW_TABS:       bit_val = m.show_tabs;
        CFG_SHOW_NONPRINT:   bit_val = m.show_nonprinting;
        default:             bit_val = 1'($urandom_range(1));
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data <= bit_val;
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    mode = m;
    settings_applied++;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_bytes.size() == 0) begin
        $error("out_byte: nothing expected, got %02h", out_data.out_byte);
        failures++;
      end else begin
        oldest = expected_bytes.pop_front();
        bytes_checked++;
        if (out_data.out_byte !== oldest.out_byte) begin
          $error("out_byte: expected %02h, got %02h", oldest.out_byte, out_data.out_byte);
          failures++;
        end
        if (out_data.last_of_run !== oldest.last_of_run) begin
          $error("last_of_run: expected %0b, got %0b", oldest.last_of_run,
                 out_data.last_of_run);
          failures++;
        end
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    int         phase;
    int         n;
    int         pick;
    cfg_t       phase_mode;
    in_item_t   item;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 28;
    recv_idle_pct = 55;
    apply_mode(MODE_PLAIN);
    foreach (directed_vectors[k]) begin
      if (directed_vectors[k].mode != mode) begin
        wait_idle();
        apply_mode(directed_vectors[k].mode);
      end
      item.data_byte = directed_vectors[k].data_byte;
      item.start_of_file = directed_vectors[k].start_of_file;
      send_byte(item, directed_vectors[k].known, directed_vectors[k].golden);
    end

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase < 3) begin
        send_idle_pct = 28;
        recv_idle_pct = 55;
      end else if (phase < 6) begin
        send_idle_pct = 55;
        recv_idle_pct = 28;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (phase == 0) phase_mode = '1;
      else if (phase == 1) phase_mode = '0;
      else phase_mode = cfg_t'($urandom_range(63));
      wait_idle();
      apply_mode(phase_mode);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // Mostly text made of lines, with runs of empty lines and the odd odd byte.
        pick = $urandom_range(99);
        if (pick < 25) item.data_byte = CH_NL;
        else if (pick < 33) item.data_byte = CH_TAB;
        else if (pick < 60) item.data_byte = 8'($urandom_range(32'h7E, 32'h20));
        else if (pick < 75) item.data_byte = 8'($urandom_range(255));
        else if (pick < 85) item.data_byte = 8'($urandom_range(31));
        else if (pick < 95) item.data_byte = 8'($urandom_range(255, 128));
        else item.data_byte = ($urandom_range(1) != 0) ? CH_DEL : CH_TOP;
        item.start_of_file = (n == 0) ? 1'($urandom_range(1)) : ($urandom_range(99) < 3);
        send_byte(item, 1'b0, "");
      end
    end

    wait_idle();
    $display("%0d text bytes sent under %0d register settings, idling on both sides",
             items_sent, settings_applied);
    $display("%0d output bytes checked, %0d mismatches", bytes_checked, failures);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
